// ===== rtl/tlb_paging_lru_frames_defines.svh =====
// Assertion macros for the paging translator
`ifndef TLB_PAGING_LRU_FRAMES_DEFINES_SVH
`define TLB_PAGING_LRU_FRAMES_DEFINES_SVH
// assert that a condition implies a consequence in the same cycle
`define TPL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");
// assert that a condition implies a consequence in the following cycle
`define TPL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");
`endif

// ===== rtl/tpl_pkg.sv =====
// Package: sizes, result codes and register indexes of the paging translator
`default_nettype none
package tpl_pkg;
  localparam int VPAGES = 256;
  localparam int FRAMES = 16;
  localparam int SLOTS  = 8;
  localparam int PW = $clog2(VPAGES);
  localparam int FW = $clog2(FRAMES);
  localparam int SW = $clog2(SLOTS);
  typedef enum logic [1:0] {
    OUT_TLB_HIT = 2'd0, OUT_TABLE_HIT = 2'd1, OUT_FAULT_FREE = 2'd2, OUT_FAULT_EVICT = 2'd3
  } outcome_t;
  localparam logic [0:0] REG_TLB_SIZE = 1'd0;
  localparam logic [0:0] REG_FRAMES   = 1'd1;
endpackage
`default_nettype wire

// ===== rtl/tlb_paging_lru_frames.sv =====
// Top level: demand-paging translator with FIFO TLB and LRU frame replacement
// A page is held in the input register and its result is registered as it moves on.
// Throughput: one transaction per cycle unless stalled; all state for a page updates in the
// cycle the page leaves the input register, so the next page looks up the fresh state.
// Table hits match the page against each frame owner; a held result stalls the input.
// Reset (synchronous, active high) empties the table, frames and TLB and zeroes the count.
`default_nettype none
`include "tlb_paging_lru_frames_defines.svh"
module tlb_paging_lru_frames (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  page,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       frame,
  output logic [1:0]       outcome,
  output logic [7:0]       evicted_page,
  output logic [15:0]      fault_count,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [4:0]  cfg_data
);
  localparam int PW = tpl_pkg::PW;
  localparam int FW = tpl_pkg::FW;
  localparam int SW = tpl_pkg::SW;
  localparam int NF = tpl_pkg::FRAMES;
  localparam int NS = tpl_pkg::SLOTS;

  logic [3:0] tlb_size;
  logic [4:0] frames_in_use;
  logic [NF-1:0] owner_valid;
  logic [PW-1:0] frame_owner [NF];
  logic [FW-1:0] recency_rank [NF];
  logic [NS-1:0] tlb_valid;
  logic [PW-1:0] tlb_tag [NS];
  logic [FW-1:0] tlb_frame [NS];
  logic [SW-1:0] tlb_next_slot;
  logic [15:0]   fault_total;
  // input register stage
  logic          busy;
  logic [PW-1:0] pg;
  logic          advance;

  assign cfg_ready = 1'b1;
  // move the held page on unless the result register is full and stalled
  assign advance  = busy && !(out_valid && out_stall);
  assign in_stall = busy && out_valid && out_stall;

  // effective sizes, clamped
  logic [4:0] nt, nf;
  always_comb begin
    nt = (tlb_size == 4'd0) ? 5'd1 : ((tlb_size > 4'(NS)) ? 5'(NS) : {1'b0, tlb_size});
    nf = (frames_in_use == 5'd0) ? 5'd1 :
         ((frames_in_use > 5'(NF)) ? 5'(NF) : frames_in_use);
  end

  // lookup logic
  logic          hit;
  logic [FW-1:0] hit_frame;
  logic          tv;
  logic [FW-1:0] tbl_frame;
  logic          free_found;
  logic [FW-1:0] free_frame, victim;
  logic [FW-1:0] vrank;
  logic [FW-1:0] res_frame;
  tpl_pkg::outcome_t res_out;
  logic [PW-1:0] res_evict;
  logic [SW-1:0] ins_slot;
  always_comb begin
    hit = 1'b0; hit_frame = '0;
    for (int i = NS-1; i >= 0; i--)
      if (5'(i) < nt && tlb_valid[i] && tlb_tag[i] == pg) begin
        hit = 1'b1; hit_frame = tlb_frame[i];
      end
    // a page is mapped exactly when some occupied frame is owned by it
    tv = 1'b0; tbl_frame = '0;
    for (int i = NF-1; i >= 0; i--)
      if (owner_valid[i] && frame_owner[i] == pg) begin
        tv = 1'b1; tbl_frame = FW'(i);
      end
    free_found = 1'b0; free_frame = '0;
    for (int i = NF-1; i >= 0; i--)
      if (5'(i) < nf && !owner_valid[i]) begin
        free_found = 1'b1; free_frame = FW'(i);
      end
    victim = '0; vrank = recency_rank[0];
    for (int i = 1; i < NF; i++)
      if (5'(i) < nf && recency_rank[i] > vrank) begin
        victim = FW'(i); vrank = recency_rank[i];
      end
    res_evict = '0;
    if (hit) begin
      res_frame = hit_frame; res_out = tpl_pkg::OUT_TLB_HIT;
    end else if (tv) begin
      res_frame = tbl_frame; res_out = tpl_pkg::OUT_TABLE_HIT;
    end else if (free_found) begin
      res_frame = free_frame; res_out = tpl_pkg::OUT_FAULT_FREE;
    end else begin
      res_frame = victim; res_out = tpl_pkg::OUT_FAULT_EVICT;
      res_evict = frame_owner[victim];
    end
    ins_slot = (5'(tlb_next_slot) < nt) ? tlb_next_slot : '0;
  end

  // state update and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      tlb_size <= 4'd8; frames_in_use <= 5'd16;
      owner_valid <= '0; tlb_valid <= '0; tlb_next_slot <= '0;
      fault_total <= '0; busy <= 1'b0; out_valid <= 1'b0;
      for (int i = 0; i < NF; i++) recency_rank[i] <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == tpl_pkg::REG_TLB_SIZE) tlb_size <= cfg_data[3:0];
        else frames_in_use <= cfg_data;
      end
      if (in_valid && !in_stall) begin
        busy <= 1'b1; pg <= page;
      end else if (advance) begin
        busy <= 1'b0;
      end
      if (advance) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      if (advance) begin
        frame <= res_frame; outcome <= res_out;
        evicted_page <= res_evict;
        if (!hit) begin
          tlb_valid[ins_slot] <= 1'b1; tlb_tag[ins_slot] <= pg;
          tlb_frame[ins_slot] <= res_frame;
          tlb_next_slot <= (5'(ins_slot) + 5'd1 >= nt) ? '0 : ins_slot + SW'(1);
        end
        if (!hit && !tv) begin
          fault_count <= (fault_total != 16'hFFFF) ? fault_total + 16'd1 : fault_total;
          if (fault_total != 16'hFFFF) fault_total <= fault_total + 16'd1;
          // the new owner takes the frame, replacing the evicted page's mapping on an eviction
          frame_owner[res_frame] <= pg;
          if (!free_found) begin
            for (int i = 0; i < NS; i++)
              if (tlb_valid[i] && tlb_tag[i] == res_evict && SW'(i) != ins_slot)
                tlb_valid[i] <= 1'b0;
          end
        end else begin
          fault_count <= fault_total;
        end
        // recency ranks
        for (int g = 0; g < NF; g++) begin
          if (FW'(g) == res_frame) recency_rank[g] <= '0;
          else if (res_out == tpl_pkg::OUT_FAULT_FREE) begin
            if (owner_valid[g] && recency_rank[g] < FW'(NF-1))
              recency_rank[g] <= recency_rank[g] + FW'(1);
          end else if (owner_valid[g] && recency_rank[g] < recency_rank[res_frame])
            recency_rank[g] <= recency_rank[g] + FW'(1);
        end
        if (res_out == tpl_pkg::OUT_FAULT_FREE) owner_valid[res_frame] <= 1'b1;
      end
    end
  end

  // an accepted transaction sets busy in the next cycle, and busy is followed by a valid result
  `TPL_ASSERT_NEXT(a_result_follows, in_valid && !in_stall, busy)
  `TPL_ASSERT_NEXT(a_busy_delivers, busy, out_valid)
  `TPL_ASSERT_IMP(a_evict_zero, out_valid && outcome != tpl_pkg::OUT_FAULT_EVICT,
                  evicted_page == 8'd0)
endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// Testbench for the paging translator: a directed pass, then random page streams under random idling
`default_nettype none
class paging_scoreboard;
  int unsigned tlb_len;
  int unsigned frame_cnt;
  bit          tbl_ok [256];
  bit [3:0]    tbl_frame [256];
  bit          own_ok [16];
  bit [7:0]    own_page [16];
  int unsigned rank [16];
  bit          slot_ok [8];
  bit [7:0]    slot_page [8];
  bit [3:0]    slot_frame [8];
  int unsigned next_slot;
  int unsigned faults;
  bit [3:0]    exp_frame [$];
  bit [1:0]    exp_outcome [$];
  bit [7:0]    exp_evicted [$];
  bit [15:0]   exp_faults [$];
  int unsigned errors;

  function new();
    tlb_len = 8;
    frame_cnt = 16;
    foreach (tbl_ok[i]) tbl_ok[i] = 0;
    foreach (own_ok[i]) begin
      own_ok[i] = 0;
      rank[i] = 0;
    end
    foreach (slot_ok[i]) slot_ok[i] = 0;
    next_slot = 0;
    faults = 0;
    errors = 0;
  endfunction

  function void write_reg(bit idx, bit [4:0] data);
    if (idx == tpl_pkg::REG_TLB_SIZE) tlb_len = data[3:0];
    else frame_cnt = data;
  endfunction

  function int unsigned eff_slots();
    if (tlb_len < 1) return 1;
    if (tlb_len > 8) return 8;
    return tlb_len;
  endfunction

  function int unsigned eff_frames();
    if (frame_cnt < 1) return 1;
    if (frame_cnt > 16) return 16;
    return frame_cnt;
  endfunction

  function void slot_fill(bit [7:0] pg, bit [3:0] f);
    int unsigned n;
    int unsigned s;
    n = eff_slots();
    s = (next_slot < n) ? next_slot : 0;
    slot_ok[s] = 1;
    slot_page[s] = pg;
    slot_frame[s] = f;
    next_slot = (s + 1 >= n) ? 0 : s + 1;
  endfunction

  // Translate one page and queue the result it must produce.
  function void note_page(bit [7:0] pg);
    int unsigned nt;
    int unsigned nf;
    int unsigned r;
    int unsigned best;
    bit [3:0] f;
    tpl_pkg::outcome_t oc;
    bit [7:0] ev;
    bit hit;
    bit got_free;
    nt = eff_slots();
    nf = eff_frames();
    f = 0;
    ev = 0;
    hit = 0;
    got_free = 0;
    for (int i = 0; i < nt && !hit; i++)
      if (slot_ok[i] && slot_page[i] == pg) begin
        f = slot_frame[i];
        hit = 1;
      end
    if (hit) oc = tpl_pkg::OUT_TLB_HIT;
    else if (tbl_ok[pg]) begin
      f = tbl_frame[pg];
      oc = tpl_pkg::OUT_TABLE_HIT;
      slot_fill(pg, f);
    end else begin
      if (faults < 65535) faults++;
      for (int i = 0; i < nf && !got_free; i++)
        if (!own_ok[i]) begin
          f = 4'(i);
          got_free = 1;
        end
      if (got_free) oc = tpl_pkg::OUT_FAULT_FREE;
      else begin
        best = 0;
        for (int i = 1; i < nf; i++)
          if (rank[i] > rank[best]) best = i;
        f = 4'(best);
        oc = tpl_pkg::OUT_FAULT_EVICT;
        ev = own_page[f];
        tbl_ok[ev] = 0;
        foreach (slot_ok[i])
          if (slot_ok[i] && slot_page[i] == ev) slot_ok[i] = 0;
      end
      own_page[f] = pg;
      tbl_ok[pg] = 1;
      tbl_frame[pg] = f;
      slot_fill(pg, f);
      if (got_free) begin
        own_ok[f] = 1;
        for (int g = 0; g < 16; g++)
          if (g != f && own_ok[g] && rank[g] < 15) rank[g]++;
        rank[f] = 0;
      end
    end
    if (oc != tpl_pkg::OUT_FAULT_FREE) begin
      r = rank[f];
      for (int g = 0; g < 16; g++)
        if (g != f && own_ok[g] && rank[g] < r) rank[g]++;
      rank[f] = 0;
    end
    exp_frame = {exp_frame, f};
    exp_outcome = {exp_outcome, oc};
    exp_evicted = {exp_evicted, ev};
    exp_faults = {exp_faults, faults[15:0]};
  endfunction

  function void check_result(bit [3:0] f, bit [1:0] oc, bit [7:0] ev, bit [15:0] fc);
    if (exp_frame.size() == 0) begin
      $display("%0t: unexpected result frame=%0d outcome=%0d", $time, f, oc);
      errors++;
      return;
    end
    if (f != exp_frame[0]) begin
      $display("%0t: frame expected %0d actual %0d", $time, exp_frame[0], f);
      errors++;
    end
    if (oc != exp_outcome[0]) begin
      $display("%0t: outcome expected %0d actual %0d", $time, exp_outcome[0], oc);
      errors++;
    end
    if (ev != exp_evicted[0]) begin
      $display("%0t: evicted_page expected %0d actual %0d", $time, exp_evicted[0], ev);
      errors++;
    end
    if (fc != exp_faults[0]) begin
      $display("%0t: fault_count expected %0d actual %0d", $time, exp_faults[0], fc);
      errors++;
    end
    void'(exp_frame.pop_front());
    void'(exp_outcome.pop_front());
    void'(exp_evicted.pop_front());
    void'(exp_faults.pop_front());
  endfunction
endclass

module tb_top;
  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_stall;
  logic [7:0]  page = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [3:0]  frame;
  logic [1:0]  outcome;
  logic [7:0]  evicted_page;
  logic [15:0] fault_count;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic        cfg_index = 0;
  logic [4:0]  cfg_data = 0;

  paging_scoreboard sb = new();
  int unsigned cycles = 0;
  bit          rx_quiet = 0;  // keep the receiver from stalling during a long stretch

  tlb_paging_lru_frames dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .page(page),
    .out_valid(out_valid), .out_stall(out_stall),
    .frame(frame), .outcome(outcome), .evicted_page(evicted_page),
    .fault_count(fault_count),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Guard the run: report a mismatch and stop if the run goes on too long.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("tlb_paging_lru_frames: mismatch");
      $finish;
    end
  end

  // Receiver: draw a stall length per result, check every accepted transaction.
  initial begin
    int unsigned wait_n;
    forever begin
      wait_n = rx_quiet ? 0 : $urandom_range(0, 19);
      if ($urandom_range(0, 3) == 0) wait_n = 0;
      if (wait_n > 0) begin
        out_stall <= 1;
        repeat (wait_n) @(posedge clk);
        out_stall <= 0;
      end
      // hold the stall low until a result is taken
      do @(posedge clk); while (!(out_valid && !out_stall));
      sb.check_result(frame, outcome, evicted_page, fault_count);
    end
  end

  // Send one page transaction after a random gap (none if no_gap is set); predict it when accepted.
  task automatic send_page(bit [7:0] pg, bit no_gap);
    int unsigned gap;
    gap = no_gap ? 0 : $urandom_range(0, 19);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    page <= pg;
    do @(posedge clk); while (!(in_valid && !in_stall));
    sb.note_page(pg);
  endtask

  // Drain all pending results, then leave the block idle before returning.
  task automatic drain();
    in_valid <= 0;
    while (sb.exp_frame.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write one register; only called when the block is idle.
  task automatic write_reg(bit idx, bit [4:0] data);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    sb.write_reg(idx, data);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  // Pick a page from a small working set so hits and evictions both come often.
  function automatic bit [7:0] pick_page(int unsigned span);
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, span));
  endfunction

  initial begin
    bit [7:0] pg;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: field extremes, fills, hits, repeat access.
    send_page(8'h00, 0);
    send_page(8'hFF, 1);
    send_page(8'h00, 1);
    send_page(8'hFF, 0);
    send_page(8'hAA, 1);
    send_page(8'h55, 1);
    drain();
    // Out-of-range register values clamp; a single frame evicts on every fault.
    write_reg(tpl_pkg::REG_TLB_SIZE, 5'd0);
    write_reg(tpl_pkg::REG_FRAMES, 5'd0);
    send_page(8'h01, 1);
    send_page(8'h02, 1);
    send_page(8'h01, 1);
    send_page(8'h02, 1);
    send_page(8'hFF, 1);
    drain();
    // Sizes above the hardware count; frames beyond the limit still translate.
    write_reg(tpl_pkg::REG_TLB_SIZE, 5'd15);
    write_reg(tpl_pkg::REG_FRAMES, 5'd31);
    send_page(8'h00, 0);
    send_page(8'h7F, 0);
    send_page(8'h80, 0);
    drain();
    write_reg(tpl_pkg::REG_TLB_SIZE, 5'd1);
    write_reg(tpl_pkg::REG_FRAMES, 5'd2);
    send_page(8'h00, 1);
    send_page(8'h80, 1);
    send_page(8'h7F, 1);
    send_page(8'hFF, 1);
    send_page(8'h80, 1);
    drain();

    // Random phases under several register settings.
    for (int ph = 0; ph < 12; ph++) begin
      int unsigned span;
      write_reg(tpl_pkg::REG_TLB_SIZE, (ph % 4 == 0) ? 5'd8 : 5'($urandom_range(0, 15)));
      write_reg(tpl_pkg::REG_FRAMES, (ph % 4 == 1) ? 5'd16 : 5'($urandom_range(0, 31)));
      span = $urandom_range(3, 40);
      rx_quiet = (ph % 5 == 2);
      for (int k = 0; k < 128; k++) begin
        pg = pick_page(span);
        send_page(pg, (ph % 5 == 3));
        if (k == 64 && ph == 6) drain();
      end
      drain();
    end

    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.exp_frame.size() == 0)
      $display("tlb_paging_lru_frames: match");
    else
      $display("tlb_paging_lru_frames: mismatch");
    $finish;
  end
endmodule
`default_nettype wire

// ===== files.f =====
+incdir+rtl
rtl/tpl_pkg.sv
rtl/tlb_paging_lru_frames.sv
dv/tb_top.sv
